@@ rtl/plc_pkg.sv @@
// Shared constants and types for the piecewise linear curve core.
// Used by plc_front, plc_queue, plc_back and piecewise_linear_curve_core.
package plc_pkg;

    localparam int MAX_POINTS = 7;
    localparam int PT_W       = $clog2(MAX_POINTS + 1);
    localparam int CFG_IDX_W  = $clog2(MAX_POINTS + 1);
    localparam int CFG_W      = 64;
    localparam int VAL_W      = 32;

    // register indexes: count first, then one per breakpoint
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = '0;

    // job kinds
    localparam logic JOB_DIRECT = 1'b0;
    localparam logic JOB_INTERP = 1'b1;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // divider: quotient bits retired per cycle
    localparam int DIV_BITS_PER_CYC = 2;
    localparam int DIV_STEPS        = VAL_W / DIV_BITS_PER_CYC;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

    typedef logic [MAX_POINTS-1:0][CFG_W-1:0] t_points;

    typedef struct packed {
        logic             kind;  // JOB_DIRECT or JOB_INTERP
        logic [VAL_W-1:0] value; // direct result, or y of the segment start
        logic             neg;   // slope falls
        logic [VAL_W-1:0] mag;   // |dy|
        logic [VAL_W-1:0] t;     // x - x_i
        logic [VAL_W-1:0] dx;    // x_(i+1) - x_i
    } t_job;

endpackage

@@ rtl/plc_front.sv @@
// Front end: takes a control word, finds the curve segment and emits a job.
// Depends on plc_pkg.
module plc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [plc_pkg::VAL_W-1:0]  i_control_value,
    output logic                       o_busy,
    input  logic [plc_pkg::PT_W-1:0]   i_point_count,
    input  plc_pkg::t_points           i_points,
    output logic                       o_push,
    output plc_pkg::t_job              o_job,
    input  logic                       i_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CLS  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                      r_phase, n_phase;
    logic [plc_pkg::VAL_W-1:0]       r_x;
    logic                            r_kind, n_kind;
    logic [plc_pkg::PT_W-1:0]        r_seg, n_seg;
    logic [plc_pkg::VAL_W-1:0]       r_val, n_val;

    logic [plc_pkg::PT_W-1:0]        n_pts;
    logic [plc_pkg::PT_W-1:0]        last;
    logic signed [plc_pkg::VAL_W-1:0] x_s;

    function automatic logic signed [plc_pkg::VAL_W-1:0] px(
        input plc_pkg::t_points p, input logic [plc_pkg::PT_W-1:0] k);
        return p[k][2*plc_pkg::VAL_W-1:plc_pkg::VAL_W];
    endfunction

    function automatic logic signed [plc_pkg::VAL_W-1:0] py(
        input plc_pkg::t_points p, input logic [plc_pkg::PT_W-1:0] k);
        return p[k][plc_pkg::VAL_W-1:0];
    endfunction

    assign o_busy = (r_phase != F_IDLE);
    assign x_s    = r_x;
    assign n_pts  = (i_point_count > plc_pkg::PT_W'(plc_pkg::MAX_POINTS)) ?
                    plc_pkg::PT_W'(plc_pkg::MAX_POINTS) : i_point_count;
    assign last   = n_pts - 1'b1;

    // classify: clamp ends, else first matching segment, else zero
    always_comb begin
        n_kind = plc_pkg::JOB_DIRECT;
        n_seg  = '0;
        n_val  = '0;
        if (n_pts == '0) begin
            n_val = '0;
        end else if (x_s <= px(i_points, '0)) begin
            n_val = py(i_points, '0);
        end else if (x_s >= px(i_points, last)) begin
            n_val = py(i_points, last);
        end else begin
            for (int i = plc_pkg::MAX_POINTS - 2; i >= 0; i--) begin
                if ((i + 1 < int'(n_pts)) &&
                    (x_s > px(i_points, plc_pkg::PT_W'(i))) &&
                    (x_s <= px(i_points, plc_pkg::PT_W'(i + 1)))) begin
                    n_kind = plc_pkg::JOB_INTERP;
                    n_seg  = plc_pkg::PT_W'(i);
                end
            end
        end
    end

    // job build from the registered segment
    logic signed [plc_pkg::VAL_W-1:0] xa, xb, ya, yb;
    logic signed [plc_pkg::VAL_W:0]   dy;
    logic        [plc_pkg::VAL_W:0]   dy_mag;

    always_comb begin
        xa     = px(i_points, r_seg);
        xb     = px(i_points, r_seg + 1'b1);
        ya     = py(i_points, r_seg);
        yb     = py(i_points, r_seg + 1'b1);
        dy     = {yb[plc_pkg::VAL_W-1], yb} - {ya[plc_pkg::VAL_W-1], ya};
        dy_mag = dy[plc_pkg::VAL_W] ? (~dy + 1'b1) : dy;

        o_job.kind = r_kind;
        if (r_kind == plc_pkg::JOB_INTERP) begin
            o_job.value = ya;
            o_job.neg   = dy[plc_pkg::VAL_W];
        end else begin
            o_job.value = r_val;
            o_job.neg   = 1'b0;
        end
        o_job.mag = dy_mag[plc_pkg::VAL_W-1:0];
        o_job.t   = x_s - xa;
        o_job.dx  = xb - xa;
    end

    assign o_push = (r_phase == F_PUSH) && !i_full;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            F_IDLE: if (i_start) n_phase = F_CLS;
            F_CLS:  n_phase = F_PUSH;
            F_PUSH: if (!i_full) n_phase = F_IDLE;
            default: n_phase = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= F_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == F_IDLE && i_start) begin
            r_x <= i_control_value;
        end
        if (r_phase == F_CLS) begin
            r_kind <= n_kind;
            r_seg  <= n_seg;
            r_val  <= n_val;
        end
    end

endmodule

@@ rtl/plc_queue.sv @@
// Short job queue between front end and back end.
// Depends on plc_pkg.
module plc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plc_pkg::t_job  i_wdata,
    input  logic           i_pop,
    output plc_pkg::t_job  o_rdata,
    output logic           o_empty,
    output logic           o_full
);

    plc_pkg::t_job               r_mem [plc_pkg::QDEPTH];
    logic [plc_pkg::QAW-1:0]     r_wp, r_rp;
    logic [plc_pkg::QAW:0]       r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (plc_pkg::QAW+1)'(plc_pkg::QDEPTH));
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/plc_back.sv @@
// Back end: multiply, iterative divide and result strobe for each job.
// Depends on plc_pkg.
module plc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  plc_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [plc_pkg::VAL_W-1:0]  o_curve_value
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_DIV  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]                       r_state;
    logic [plc_pkg::VAL_W-1:0]        r_val, r_mag, r_t, r_dx;
    logic                             r_neg;
    logic [plc_pkg::VAL_W-1:0]        r_rem, r_quo, n_rem, n_quo;
    logic [plc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic                             r_valid;
    logic [plc_pkg::VAL_W-1:0]        r_y;

    assign o_pop         = (r_state == B_IDLE) && !i_empty;
    assign o_valid       = r_valid;
    assign o_curve_value = r_y;

    // DIV_BITS_PER_CYC restoring steps; the remainder stays below the divisor
    always_comb begin
        logic [plc_pkg::VAL_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int s = 0; s < plc_pkg::DIV_BITS_PER_CYC; s++) begin
            trial = {n_rem, n_quo[plc_pkg::VAL_W-1]};
            if (trial >= {1'b0, r_dx}) begin
                trial = trial - {1'b0, r_dx};
                n_quo = {n_quo[plc_pkg::VAL_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[plc_pkg::VAL_W-2:0], 1'b0};
            end
            n_rem = trial[plc_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_job.kind == plc_pkg::JOB_INTERP) ? B_MUL : B_OUT;
                    end
                end
                B_MUL: begin
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == plc_pkg::DIV_CNT_W'(plc_pkg::DIV_STEPS - 1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_val <= i_job.value;
                r_neg <= i_job.neg;
                r_mag <= i_job.mag;
                r_t   <= i_job.t;
                r_dx  <= i_job.dx;
                r_rem <= '0;
                r_quo <= '0;
            end
            B_MUL: begin
                // product high word is below dx since t <= dx
                {r_rem, r_quo} <= (2*plc_pkg::VAL_W)'(r_mag) *
                                  (2*plc_pkg::VAL_W)'(r_t);
            end
            B_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            B_OUT: begin
                r_y <= r_neg ? (r_val - r_quo) : (r_val + r_quo);
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule

@@ rtl/piecewise_linear_curve_core.sv @@
// Top level of the piecewise linear curve core: configuration registers,
// front end, job queue and back end. Depends on plc_pkg and all plc_* modules.
//
// Give the core a signed Q16.16 control word on i_control_value with i_start
// while o_busy is low; it answers with one Q16.16 curve word on o_curve_value,
// marked by a single-cycle o_valid strobe that cannot be held off, so sample it
// on the spot. Up to seven breakpoints sit in configuration registers (index 0
// is the point count, indexes 1 to 7 hold x in bits 63:32 and y in bits 31:0);
// write them only while the core is idle. Below the first x the first y comes
// back, above the last x the last y, an empty curve or unsorted points with no
// matching segment give zero, and in between the value is interpolated with
// the quotient truncated toward zero. The front end registers an accepted
// item, classifies it in F_CLS and queues a job in F_PUSH once the queue has
// room, then drops o_busy; the back end pops each job in B_IDLE, then for an
// interpolated one runs the multiply state B_MUL and the divider in B_DIV (two
// quotient bits a cycle) before B_OUT drives the result; a clamped job goes
// straight to B_OUT. Back to back, the divider sets the pace for interpolated
// words, and the two-entry queue lets the front end take the next word
// meanwhile.
module piecewise_linear_curve_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [plc_pkg::VAL_W-1:0]      i_control_value,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [plc_pkg::VAL_W-1:0]      o_curve_value,
    input  logic                           i_cfg_we,
    input  logic [plc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plc_pkg::CFG_W-1:0]      i_cfg_wdata
);

    logic [plc_pkg::PT_W-1:0]  r_point_count;
    plc_pkg::t_points          r_points;

    logic          q_push, q_pop, q_empty, q_full;
    plc_pkg::t_job q_wdata, q_rdata;

    // hold the curve; a write lands at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_points      <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == plc_pkg::REG_POINT_COUNT) begin
                r_point_count <= i_cfg_wdata[plc_pkg::PT_W-1:0];
            end else begin
                r_points[plc_pkg::PT_W'(i_cfg_index - 1'b1)] <= i_cfg_wdata;
            end
        end
    end

    // accept and classify
    plc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_control_value (i_control_value),
        .o_busy          (o_busy),
        .i_point_count   (r_point_count),
        .i_points        (r_points),
        .o_push          (q_push),
        .o_job           (q_wdata),
        .i_full          (q_full)
    );

    // decouple front and back
    plc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // multiply, divide, drive the result word
    plc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_job         (q_rdata),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_curve_value (o_curve_value)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("job popped from an empty queue");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("front end did not hold the accepted word");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");
`endif

endmodule

@@ tb/piecewise_linear_curve_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_curve_core: a scoreboard class
// predicts each curve word from its own copy of the breakpoint registers.
// Depends on plc_pkg and the piecewise_linear_curve_core RTL.

class curve_scoreboard;
    logic [plc_pkg::PT_W-1:0]  count_r;
    logic [plc_pkg::CFG_W-1:0] pts [plc_pkg::MAX_POINTS];
    logic [plc_pkg::VAL_W-1:0] want_q [$];
    int                        errors;
    int                        checked;

    function new();
        count_r = '0;
        foreach (pts[i]) pts[i] = '0;
        errors  = 0;
        checked = 0;
    endfunction

    // Mirror a register write; index 0 is the count, the rest are breakpoints.
    function void set_reg(logic [plc_pkg::CFG_IDX_W-1:0] idx,
                          logic [plc_pkg::CFG_W-1:0] data);
        if (idx == plc_pkg::REG_POINT_COUNT)
            count_r = data[plc_pkg::PT_W-1:0];
        else
            pts[idx - 1'b1] = data;
    endfunction

    function longint x_of(int i);
        x_of = longint'($signed(pts[i][63:32]));
    endfunction

    function longint y_of(int i);
        y_of = longint'($signed(pts[i][31:0]));
    endfunction

    function logic [plc_pkg::VAL_W-1:0] curve_at(logic [plc_pkg::VAL_W-1:0] x);
        int                        n;
        longint                    sx;
        longint                    xa;
        longint                    xb;
        longint                    ya;
        longint                    dy;
        logic [63:0]               mag;
        logic [63:0]               t;
        logic [63:0]               dx;
        logic [63:0]               q;
        logic [63:0]               full;
        logic [plc_pkg::VAL_W-1:0] res;
        n  = int'(count_r);
        sx = longint'($signed(x));
        if (n == 0)
            return '0;
        if (sx <= x_of(0))
            return pts[0][31:0];
        if (sx >= x_of(n - 1))
            return pts[n - 1][31:0];
        for (int i = 0; i + 1 < n; i++) begin
            xa = x_of(i);
            xb = x_of(i + 1);
            if (sx > xa && sx <= xb) begin
                ya   = y_of(i);
                dy   = y_of(i + 1) - ya;
                dx   = xb - xa;
                t    = sx - xa;
                mag  = (dy < 0) ? -dy : dy;
                q    = (mag * t) / dx;
                full = (dy < 0) ? ya - q : ya + q;
                res  = full[plc_pkg::VAL_W-1:0];
                return res;
            end
        end
        return '0;
    endfunction

    function void note_control(logic [plc_pkg::VAL_W-1:0] x);
        want_q.insert(want_q.size(), curve_at(x));
    endfunction

    function void check_curve(logic [plc_pkg::VAL_W-1:0] y);
        logic [plc_pkg::VAL_W-1:0] want;
        if (want_q.size() == 0) begin
            $error("curve_value: word with nothing pending, expected none, actual %h", y);
            errors++;
            return;
        end
        want = want_q.pop_front();
        checked++;
        if (y !== want) begin
            $error("curve_value mismatch: expected %h, actual %h", want, y);
            errors++;
        end
    endfunction

    function int pending();
        return want_q.size();
    endfunction
endclass

module piecewise_linear_curve_core_test;

    localparam logic [plc_pkg::CFG_IDX_W-1:0] REG_POINT_BASE = 1;
    localparam int                            RANDOM_WORDS   = 1700;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic [plc_pkg::VAL_W-1:0]     i_control_value;
    logic                          o_busy;
    logic                          o_valid;
    logic [plc_pkg::VAL_W-1:0]     o_curve_value;
    logic                          i_cfg_we;
    logic [plc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [plc_pkg::CFG_W-1:0]     i_cfg_wdata;

    curve_scoreboard sb = new();

    // Curve currently programmed into the core.
    int cur_x [plc_pkg::MAX_POINTS];
    int cur_y [plc_pkg::MAX_POINTS];
    int cur_n;

    int words_sent;
    int settings_run;

    piecewise_linear_curve_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_control_value (i_control_value),
        .o_busy          (o_busy),
        .o_valid         (o_valid),
        .o_curve_value   (o_curve_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watch both handshakes at the edge. Values read here are the ones from
    // before the edge, which is what the core sampled. Check the result first:
    // a word accepted at this edge cannot have its answer out yet.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_curve(o_curve_value);
            if (i_start && !o_busy)
                sb.note_control(i_control_value);
        end
    end

    // Offer one control word and hold it until the core takes it. An optional
    // idle gap goes in front so that pauses land on every stage of the work.
    task automatic send_word(input logic [plc_pkg::VAL_W-1:0] x, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 99) < 9) begin
            gap = $urandom_range(1, 30);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_control_value <= x;
        do @(posedge i_clk); while (o_busy);
        words_sent++;
    endtask

    // Drop start and hold until every predicted word has come back. Poll on
    // the falling edge so the monitor has already run for the rising one,
    // then line up on a rising edge again for the next drive.
    task automatic wait_drained();
        i_start <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    // Program the count and all seven breakpoints; only call while idle.
    // The count goes out with junk in its upper bits, which the core drops.
    task automatic load_curve();
        logic [plc_pkg::CFG_W-1:0] data;
        for (int r = 0; r <= plc_pkg::MAX_POINTS; r++) begin
            if (r == 0) begin
                data = ({$urandom, $urandom} & ~64'h7) | 64'(cur_n);
                i_cfg_index <= plc_pkg::REG_POINT_COUNT;
            end else begin
                data = {cur_x[r - 1], cur_y[r - 1]};
                i_cfg_index <= REG_POINT_BASE + plc_pkg::CFG_IDX_W'(r - 1);
            end
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= data;
            @(posedge i_clk);
            sb.set_reg((r == 0) ? plc_pkg::REG_POINT_COUNT :
                       REG_POINT_BASE + plc_pkg::CFG_IDX_W'(r - 1), data);
        end
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial begin
        int          shape;
        int          narrow;
        int          acc;
        int          tmp;
        int          phase_words;
        int          rand_sent;
        int          r;
        int          j;
        logic [31:0] x;
        longint      lo;
        longint      span;
        longint      off;

        words_sent   = 0;
        settings_run = 0;
        rand_sent    = 0;

        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_control_value <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers straight out of reset: empty curve, every word gives zero.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        wait_drained();

        // Full seven-point curve with x and y at the rails, rising and
        // falling slopes, and the widest possible segments.
        cur_x = '{32'h8000_0000, -1000, 0, 1, 2, 100000, 32'h7fff_ffff};
        cur_y = '{32'h7fff_ffff, 32'h8000_0000, 5, -7, 32'h7fff_ffff, 32'h8000_0000, 1234};
        cur_n = plc_pkg::MAX_POINTS;
        load_curve();
        send_word(32'h8000_0000, 1'b0);  // at the first x
        send_word(32'h7fff_ffff, 1'b0);  // at the last x
        send_word(-1000, 1'b0);          // exactly on an inner breakpoint
        send_word(32'h8000_0001, 1'b0);  // first segment, |dy| near 2^32
        send_word(-500, 1'b0);
        send_word(1, 1'b0);
        send_word(2, 1'b0);
        send_word(50000, 1'b0);          // falling full-range segment
        send_word(32'h7fff_fffe, 1'b0);
        send_word(12345, 1'b0);
        wait_drained();

        // Unsorted points: the first segment that brackets x wins.
        cur_x = '{100, -50, 300, 200, 400, 0, 0};
        cur_y = '{10, -20, 30, -40, 50, 0, 0};
        cur_n = 5;
        load_curve();
        send_word(100, 1'b0);
        send_word(150, 1'b0);
        send_word(250, 1'b0);
        send_word(350, 1'b0);
        send_word(450, 1'b0);
        wait_drained();

        // Single point: below, on and above it all give its y.
        cur_x[0] = 7;
        cur_n    = 1;
        load_curve();
        send_word(6, 1'b0);
        send_word(7, 1'b0);
        send_word(8, 1'b0);
        wait_drained();

        // Empty curve with live points still loaded.
        cur_n = 0;
        load_curve();
        send_word(12345, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        wait_drained();

        // Random curves, one setting per phase, with control words aimed
        // mostly at breakpoints and segment interiors.
        while (rand_sent < RANDOM_WORDS) begin
            shape  = $urandom_range(0, 9);
            narrow = $urandom_range(0, 1);
            acc    = 0;
            tmp    = $urandom;
            for (int k = 0; k < plc_pkg::MAX_POINTS; k++) begin
                if (narrow) begin
                    cur_x[k] = tmp + acc;
                    acc += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5000);
                end else begin
                    cur_x[k] = $urandom;
                end
                if (shape == 2)
                    cur_y[k] = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
                else if ($urandom_range(0, 3) == 0)
                    cur_y[k] = $urandom_range(0, 2000) - 1000;
                else
                    cur_y[k] = $urandom;
            end
            // Shape 1 keeps the points unsorted; all others get them sorted.
            if (shape != 1) begin
                for (int a = 0; a < plc_pkg::MAX_POINTS - 1; a++)
                    for (int b = 0; b < plc_pkg::MAX_POINTS - 1 - a; b++)
                        if (cur_x[b] > cur_x[b + 1]) begin
                            tmp          = cur_x[b];
                            cur_x[b]     = cur_x[b + 1];
                            cur_x[b + 1] = tmp;
                        end
            end
            if (shape == 0)
                cur_n = 0;
            else if (shape == 3 || shape == 2)
                cur_n = plc_pkg::MAX_POINTS;
            else
                cur_n = $urandom_range(1, plc_pkg::MAX_POINTS);
            load_curve();

            phase_words = $urandom_range(40, 140);
            for (int k = 0; k < phase_words; k++) begin
                r = $urandom_range(0, 99);
                if (r >= 92) begin
                    x = r[0] ? 32'h7fff_ffff : 32'h8000_0000;
                end else if (r < 15 || cur_n < 2) begin
                    x = $urandom;
                end else if (r < 35) begin
                    j = $urandom_range(0, cur_n - 1);
                    x = cur_x[j] + $urandom_range(0, 2) - 1;
                end else begin
                    j    = $urandom_range(0, cur_n - 2);
                    lo   = longint'(cur_x[j]);
                    span = longint'(cur_x[j + 1]) - lo;
                    if (span > 0) begin
                        off = {$urandom, $urandom} % (span + 1);
                        x   = 32'(lo + off);
                    end else begin
                        x = $urandom;
                    end
                end
                // Hold off once mid-phase until the core has fully emptied.
                if (rand_sent == 300)
                    wait_drained();
                // Run a long stretch back to back with no random idle gaps.
                send_word(x, !(rand_sent >= 600 && rand_sent < 1000));
                rand_sent++;
            end
            wait_drained();
        end

        // Give any stray extra word time to show up before the verdict.
        repeat (40) @(posedge i_clk);
        $display("Covered %0d control words over %0d curve settings (empty, single point,",
                 words_sent, settings_run);
        $display("unsorted, rail values); %0d words checked, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
